// File: hw/rtl/imufp_pkg.sv
// ----------------------------------------------------------------------------
// imufp_pkg
// Types and constants shared by the serial IMU frame parser.
// ----------------------------------------------------------------------------
package imufp_pkg;

	typedef enum logic [1:0] {
		KIND_ACCEL   = 2'd0,
		KIND_GYRO    = 2'd1,
		KIND_ANGLE   = 2'd2,
		KIND_IGNORED = 2'd3
	} frame_kind_t;

	localparam int unsigned CfgIndexW = 3;

	localparam logic [CfgIndexW-1:0] REG_HEADER     = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_ACCEL_CODE = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_GYRO_CODE  = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_ANGLE_CODE = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_ACCEL_EN   = 3'd4;

	localparam logic [7:0] HEADER_RESET     = 8'h55;
	localparam logic [7:0] ACCEL_CODE_RESET = 8'h51;
	localparam logic [7:0] GYRO_CODE_RESET  = 8'h52;
	localparam logic [7:0] ANGLE_CODE_RESET = 8'h53;

	localparam int unsigned YawW = 48;
	localparam int unsigned CountW = 32;

	// Last frame byte that carries payload (the extra word's high byte).
	localparam int unsigned LastFieldByte = 9;

endpackage

// File: hw/rtl/imu_frame_parser_yaw_unwrap.sv
// ----------------------------------------------------------------------------
// imu_frame_parser_yaw_unwrap
// Parses a serial IMU byte stream into checked frames and unwraps the yaw.
// ----------------------------------------------------------------------------
// The block accepts one stream byte per clock while results are taken, and
// keeps a running checksum and byte counter. A byte is held in an input
// register while the frame state is updated; when it is the checksum byte
// of a frame, the result is loaded into the output register behind the
// input register. A stalled result holds the input register and the frame
// state, so the block keeps the full rate as long as results are taken.
// Configuration writes are never stalled.
module imu_frame_parser_yaw_unwrap import imufp_pkg::*; #(
	parameter int unsigned FRAME_BYTES = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [7:0]           cfg_data,

	input  logic                 data_valid,
	output logic                 data_ready,
	input  logic [7:0]           data_byte,

	output logic                 result_valid,
	input  logic                 result_ready,
	output logic                 checksum_ok,
	output logic [1:0]           frame_kind,
	output logic signed [15:0]   axis_x,
	output logic signed [15:0]   axis_y,
	output logic signed [15:0]   axis_z,
	output logic [15:0]          extra_word,
	output logic signed [YawW-1:0] yaw_total,
	output logic [CountW-1:0]    good_count,
	output logic [CountW-1:0]    bad_count
);

	localparam int unsigned PosW = $clog2(FRAME_BYTES);
	localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);

	logic [7:0] header_q, accel_code_q, gyro_code_q, angle_code_q;
	logic       accel_en_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	logic [PosW-1:0]   pos_q;
	logic [7:0]        sum_q;
	logic [7:0]        frame_q [1:LastFieldByte];
	logic              seeded_q;
	logic [15:0]       prev_yaw_q;
	logic [YawW-1:0]   acc_q;
	logic [CountW-1:0] good_q, bad_q;

	logic              is_header, is_last, finish;
	logic              ok;
	frame_kind_t       kind;
	logic [15:0]       word_x, word_y, word_z, word_e;
	logic signed [16:0] delta_raw, delta;
	logic [YawW-1:0]   acc_next;
	logic              take_yaw;

	logic              ok_q;
	frame_kind_t       kind_q;
	logic [15:0]       x_q, y_q, z_q, e_q;
	logic [YawW-1:0]   yaw_q;
	logic [CountW-1:0] good_out_q, bad_out_q;
	logic              result_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q     <= HEADER_RESET;
			accel_code_q <= ACCEL_CODE_RESET;
			gyro_code_q  <= GYRO_CODE_RESET;
			angle_code_q <= ANGLE_CODE_RESET;
			accel_en_q   <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HEADER:     header_q     <= cfg_data;
				REG_ACCEL_CODE: accel_code_q <= cfg_data;
				REG_GYRO_CODE:  gyro_code_q  <= cfg_data;
				REG_ANGLE_CODE: angle_code_q <= cfg_data;
				REG_ACCEL_EN:   accel_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign data_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ready && data_valid) begin
			byte_s1 <= data_byte;
		end
	end

	assign is_header = (byte_s1 == header_q);
	assign is_last   = (pos_q == LastPos);
	assign finish    = advance && is_last;

	assign ok     = (sum_q == byte_s1);
	assign word_x = {frame_q[3], frame_q[2]};
	assign word_y = {frame_q[5], frame_q[4]};
	assign word_z = {frame_q[7], frame_q[6]};
	assign word_e = {frame_q[9], frame_q[8]};

	always_comb begin
		kind = KIND_IGNORED;
		if (ok) begin
			if (frame_q[1] == accel_code_q) begin
				kind = accel_en_q ? KIND_ACCEL : KIND_IGNORED;
			end else if (frame_q[1] == gyro_code_q) begin
				kind = KIND_GYRO;
			end else if (frame_q[1] == angle_code_q) begin
				kind = KIND_ANGLE;
			end
		end
	end

	assign take_yaw  = finish && (kind == KIND_ANGLE);
	assign delta_raw = {word_z[15], word_z} - {prev_yaw_q[15], prev_yaw_q};

	always_comb begin
		delta = delta_raw;
		if (delta_raw > 17'sd32768) begin
			delta = delta_raw - 17'sd65536;
		end else if (delta_raw < -17'sd32768) begin
			delta = delta_raw + 17'sd65536;
		end
		if (seeded_q) begin
			acc_next = acc_q + {{(YawW-17){delta[16]}}, delta};
		end else begin
			acc_next = {{(YawW-16){word_z[15]}}, word_z};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (advance) begin
			if (pos_q == '0) begin
				if (is_header) begin
					pos_q <= PosW'(1);
				end
			end else if (pos_q == PosW'(1) && is_header) begin
				pos_q <= PosW'(1);
			end else if (is_last) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + PosW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (pos_q == '0 || (pos_q == PosW'(1) && is_header)) begin
				sum_q <= byte_s1;
			end else begin
				sum_q <= sum_q + byte_s1;
			end
		end
	end

	for (genvar i = 1; i <= LastFieldByte; i++) begin : g_store
		always_ff @(posedge clk) begin
			if (advance && pos_q == PosW'(i) && !(i == 1 && is_header)) begin
				frame_q[i] <= byte_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q   <= 1'b0;
			prev_yaw_q <= '0;
			acc_q      <= '0;
			good_q     <= '0;
			bad_q      <= '0;
		end else begin
			if (take_yaw) begin
				seeded_q   <= 1'b1;
				prev_yaw_q <= word_z;
				acc_q      <= acc_next;
			end
			if (finish) begin
				if (ok) begin
					good_q <= good_q + CountW'(1);
				end else begin
					bad_q <= bad_q + CountW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (finish) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			ok_q       <= ok;
			kind_q     <= kind;
			x_q        <= (kind == KIND_IGNORED) ? 16'd0 : word_x;
			y_q        <= (kind == KIND_IGNORED) ? 16'd0 : word_y;
			z_q        <= (kind == KIND_IGNORED) ? 16'd0 : word_z;
			e_q        <= (kind == KIND_IGNORED) ? 16'd0 : word_e;
			yaw_q      <= take_yaw ? acc_next : acc_q;
			good_out_q <= ok ? good_q + CountW'(1) : good_q;
			bad_out_q  <= ok ? bad_q : bad_q + CountW'(1);
		end
	end

	assign result_valid = result_valid_q;
	assign checksum_ok  = ok_q;
	assign frame_kind   = kind_q;
	assign axis_x       = x_q;
	assign axis_y       = y_q;
	assign axis_z       = z_q;
	assign extra_word   = e_q;
	assign yaw_total    = yaw_q;
	assign good_count   = good_out_q;
	assign bad_count    = bad_out_q;

	// The accumulator's low half always equals the last raw yaw angle.
	a_yaw_low: assert property (@(posedge clk) disable iff (!arst_n)
		seeded_q |-> acc_q[15:0] == prev_yaw_q)
		else $error("yaw accumulator lost track of the raw angle");

	a_unseeded: assert property (@(posedge clk) disable iff (!arst_n)
		!seeded_q |-> acc_q == '0)
		else $error("yaw accumulator moved before the first angle frame");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !ok_q |-> kind_q == KIND_IGNORED && x_q == 16'd0 && e_q == 16'd0)
		else $error("bad frame reported with payload");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LastPos)
		else $error("byte position ran past the frame");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> good_out_q + bad_out_q == $past(good_q + bad_q) + CountW'(1))
		else $error("frame counters did not advance by one");

endmodule

// File: tb/imu_frame_parser_yaw_unwrap_tb.sv
// ----------------------------------------------------------------------------
// imu_frame_parser_yaw_unwrap_tb
// Self-checking testbench for the serial IMU frame parser with yaw unwrap.
// A queue-fed driver streams bytes in random bursts while the result side
// stalls on its own pattern. A behavioral parser tracks every accepted byte
// and predicts each frame result, which is compared field by field against
// the block. The run steps through several register settings, from reset
// values to extremes and colliding type codes.
// ----------------------------------------------------------------------------
module imu_frame_parser_yaw_unwrap_tb import imufp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_LEN = 11;
	localparam int RESET_CYCLES = 10;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 150;

	typedef struct {
		logic                   ok;
		frame_kind_t            kind;
		logic signed [15:0]     x;
		logic signed [15:0]     y;
		logic signed [15:0]     z;
		logic [15:0]            extra;
		logic signed [YawW-1:0] yaw;
		logic [CountW-1:0]      good;
		logic [CountW-1:0]      bad;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;

	logic       data_valid = 1'b0;
	logic       data_ready;
	logic [7:0] data_byte = '0;

	logic                   result_valid;
	logic                   result_ready = 1'b0;
	logic                   checksum_ok;
	logic [1:0]             frame_kind;
	logic signed [15:0]     axis_x;
	logic signed [15:0]     axis_y;
	logic signed [15:0]     axis_z;
	logic [15:0]            extra_word;
	logic signed [YawW-1:0] yaw_total;
	logic [CountW-1:0]      good_count;
	logic [CountW-1:0]      bad_count;

	imu_frame_parser_yaw_unwrap #(
		.FRAME_BYTES(FRAME_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.data_valid(data_valid),
		.data_ready(data_ready),
		.data_byte(data_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.checksum_ok(checksum_ok),
		.frame_kind(frame_kind),
		.axis_x(axis_x),
		.axis_y(axis_y),
		.axis_z(axis_z),
		.extra_word(extra_word),
		.yaw_total(yaw_total),
		.good_count(good_count),
		.bad_count(bad_count)
	);

	always #6 clk = ~clk;

	// Parser copy: registers and frame state.
	logic [7:0]        reg_header;
	logic [7:0]        reg_accel_code;
	logic [7:0]        reg_gyro_code;
	logic [7:0]        reg_angle_code;
	logic              reg_accel_en;
	int                byte_pos;
	logic [7:0]        frame_buf [FRAME_LEN];
	logic              yaw_seeded;
	logic [15:0]       prev_yaw;
	logic [YawW-1:0]   yaw_acc;
	logic [CountW-1:0] good_frames;
	logic [CountW-1:0] bad_frames;

	frame_result_t expected_frames [$];
	logic [7:0]    tx_bytes [$];
	int            mismatch_count = 0;
	int            cycle_count = 0;

	// Stimulus copy of the register settings and the last yaw sent.
	logic [7:0]  stim_header = HEADER_RESET;
	logic [7:0]  stim_accel = ACCEL_CODE_RESET;
	logic [7:0]  stim_gyro = GYRO_CODE_RESET;
	logic [7:0]  stim_angle = ANGLE_CODE_RESET;
	logic [15:0] stim_last_yaw = '0;
	int          frame_bytes_sent = 0;

	task automatic apply_reg_write(input logic [CfgIndexW-1:0] idx, input logic [7:0] val);
		case (idx)
			REG_HEADER: reg_header = val;
			REG_ACCEL_CODE: reg_accel_code = val;
			REG_GYRO_CODE: reg_gyro_code = val;
			REG_ANGLE_CODE: reg_angle_code = val;
			REG_ACCEL_EN: reg_accel_en = val[0];
			default: ;
		endcase
	endtask

	task automatic unwrap_yaw(input logic [15:0] raw);
		int cur_yaw;
		int step;
		cur_yaw = int'($signed(raw));
		if (!yaw_seeded) begin
			yaw_acc = YawW'(longint'(cur_yaw));
			yaw_seeded = 1'b1;
		end else begin
			step = cur_yaw - int'($signed(prev_yaw));
			if (step > 32768)
				step -= 65536;
			else if (step < -32768)
				step += 65536;
			yaw_acc = yaw_acc + YawW'(longint'(step));
		end
		prev_yaw = raw;
	endtask

	task automatic close_frame();
		frame_result_t res;
		logic [7:0] sum;
		sum = '0;
		for (int i = 0; i < FRAME_LEN - 1; i++)
			sum += frame_buf[i];
		res.ok = (sum == frame_buf[FRAME_LEN-1]);
		res.kind = KIND_IGNORED;
		res.x = '0;
		res.y = '0;
		res.z = '0;
		res.extra = '0;
		if (!res.ok) begin
			bad_frames++;
		end else begin
			good_frames++;
			if (frame_buf[1] == reg_accel_code)
				res.kind = reg_accel_en ? KIND_ACCEL : KIND_IGNORED;
			else if (frame_buf[1] == reg_gyro_code)
				res.kind = KIND_GYRO;
			else if (frame_buf[1] == reg_angle_code)
				res.kind = KIND_ANGLE;
			if (res.kind != KIND_IGNORED) begin
				res.x = {frame_buf[3], frame_buf[2]};
				res.y = {frame_buf[5], frame_buf[4]};
				res.z = {frame_buf[7], frame_buf[6]};
				res.extra = {frame_buf[9], frame_buf[8]};
			end
			if (res.kind == KIND_ANGLE)
				unwrap_yaw({frame_buf[7], frame_buf[6]});
		end
		res.yaw = yaw_acc;
		res.good = good_frames;
		res.bad = bad_frames;
		expected_frames.push_back(res);
	endtask

	task automatic parse_stream_byte(input logic [7:0] b);
		if (byte_pos == 0) begin
			if (b == reg_header) begin
				frame_buf[0] = b;
				byte_pos = 1;
			end
		end else if (byte_pos == 1 && b == reg_header) begin
			frame_buf[0] = b;
		end else begin
			frame_buf[byte_pos] = b;
			byte_pos++;
			if (byte_pos == FRAME_LEN) begin
				byte_pos = 0;
				close_frame();
			end
		end
	endtask

	task automatic compare_field(input string field, input logic signed [63:0] expv,
			input logic signed [63:0] actv);
		if (expv !== actv) begin
			$error("%s: expected %0d, actual %0d", field, expv, actv);
			mismatch_count++;
		end
	endtask

	// Monitor: tracks register writes and accepted bytes, checks results.
	always @(posedge clk or negedge arst_n) begin
		frame_result_t exp_res;
		if (!arst_n) begin
			reg_header = HEADER_RESET;
			reg_accel_code = ACCEL_CODE_RESET;
			reg_gyro_code = GYRO_CODE_RESET;
			reg_angle_code = ANGLE_CODE_RESET;
			reg_accel_en = 1'b1;
			byte_pos = 0;
			yaw_seeded = 1'b0;
			prev_yaw = '0;
			yaw_acc = '0;
			good_frames = '0;
			bad_frames = '0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_reg_write(cfg_index, cfg_data);
			if (data_valid && data_ready)
				parse_stream_byte(data_byte);
			if (result_valid && result_ready) begin
				if (expected_frames.size() == 0) begin
					$error("result with no frame pending");
					mismatch_count++;
				end else begin
					exp_res = expected_frames.pop_front();
					compare_field("checksum_ok", exp_res.ok, checksum_ok);
					compare_field("frame_kind", exp_res.kind, frame_kind);
					compare_field("axis_x", exp_res.x, axis_x);
					compare_field("axis_y", exp_res.y, axis_y);
					compare_field("axis_z", exp_res.z, axis_z);
					compare_field("extra_word", exp_res.extra, extra_word);
					compare_field("yaw_total", exp_res.yaw, yaw_total);
					compare_field("good_count", exp_res.good, good_count);
					compare_field("bad_count", exp_res.bad, bad_count);
				end
			end
		end
	end

	// Byte driver: bursts of random length separated by random gaps.
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_valid <= 1'b0;
			data_byte <= '0;
			burst_left = 0;
			gap_left = 0;
		end else if (!data_valid || data_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				data_valid <= 1'b0;
			end else if (tx_bytes.size() > 0) begin
				data_valid <= 1'b1;
				data_byte <= tx_bytes.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				data_valid <= 1'b0;
			end
		end
	end

	// Result side: stall behavior switches between several patterns.
	int stall_left;
	int ready_mode;
	int mode_timer;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left = 0;
			ready_mode = 0;
			mode_timer = 0;
		end else begin
			if (mode_timer == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_timer = $urandom_range(50, 300);
			end else begin
				mode_timer--;
			end
			if (stall_left > 0) begin
				stall_left--;
			end else begin
				case (ready_mode)
					1: stall_left = $urandom_range(0, 1);
					2: stall_left = $urandom_range(0, 3);
					3: stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : 0;
					default: stall_left = 0;
				endcase
			end
			result_ready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] hdr, input logic [7:0] accel,
			input logic [7:0] gyro, input logic [7:0] angle, input logic [7:0] en_data);
		write_reg(REG_HEADER, hdr);
		write_reg(REG_ACCEL_CODE, accel);
		write_reg(REG_GYRO_CODE, gyro);
		write_reg(REG_ANGLE_CODE, angle);
		write_reg(REG_ACCEL_EN, en_data);
		stim_header = hdr;
		stim_accel = accel;
		stim_gyro = gyro;
		stim_angle = angle;
	endtask

	// Writes to indexes past the last register must leave the settings alone.
	task automatic write_unused_regs();
		for (int i = int'(REG_ACCEL_EN) + 1; i < (1 << CfgIndexW); i++)
			write_reg(CfgIndexW'(i), 8'($urandom));
	endtask

	task automatic wait_idle();
		while (tx_bytes.size() != 0 || data_valid || expected_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_frame(input logic [7:0] kind_byte, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] z, input logic [15:0] extra,
			input bit corrupt);
		logic [7:0] frame [FRAME_LEN];
		logic [7:0] sum;
		frame[0] = stim_header;
		frame[1] = kind_byte;
		frame[2] = x[7:0];
		frame[3] = x[15:8];
		frame[4] = y[7:0];
		frame[5] = y[15:8];
		frame[6] = z[7:0];
		frame[7] = z[15:8];
		frame[8] = extra[7:0];
		frame[9] = extra[15:8];
		for (int i = 10; i < FRAME_LEN - 1; i++)
			frame[i] = 8'($urandom);
		sum = '0;
		for (int i = 0; i < FRAME_LEN - 1; i++)
			sum += frame[i];
		frame[FRAME_LEN-1] = corrupt ? sum + 8'($urandom_range(1, 255)) : sum;
		for (int i = 0; i < FRAME_LEN; i++)
			tx_bytes.push_back(frame[i]);
		frame_bytes_sent += FRAME_LEN;
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'h7FFF;
			2: return 16'h8000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Yaw steps around the half-turn boundary, small drifts and jumps.
	function automatic logic [15:0] pick_yaw();
		logic [15:0] yaw;
		case ($urandom_range(0, 5))
			0: yaw = stim_last_yaw + 16'h8000;
			1: yaw = stim_last_yaw + 16'h8001;
			2: yaw = stim_last_yaw + 16'h7FFF;
			3: yaw = stim_last_yaw + 16'($urandom_range(0, 200)) - 16'd100;
			4: yaw = pick_word();
			default: yaw = 16'($urandom);
		endcase
		stim_last_yaw = yaw;
		return yaw;
	endfunction

	task automatic random_frame();
		logic [7:0] kind_byte;
		logic [15:0] z;
		case ($urandom_range(0, 5))
			0: kind_byte = stim_accel;
			1: kind_byte = stim_gyro;
			2, 3: kind_byte = stim_angle;
			default: kind_byte = 8'($urandom);
		endcase
		z = (kind_byte == stim_angle) ? pick_yaw() : pick_word();
		add_frame(kind_byte, pick_word(), pick_word(), z, pick_word(),
			$urandom_range(0, 9) == 0);
	endtask

	task automatic random_traffic(input int target_bytes);
		int start_bytes;
		int pick;
		start_bytes = frame_bytes_sent;
		@(negedge clk);
		while (frame_bytes_sent - start_bytes < target_bytes) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom));
			end else if (pick < 14) begin
				tx_bytes.push_back(stim_header);
				repeat ($urandom_range(0, 6)) tx_bytes.push_back(8'($urandom));
			end else begin
				if (pick < 22)
					tx_bytes.push_back(stim_header);
				random_frame();
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames under reset settings.
		tx_bytes.push_back(8'h00);
		tx_bytes.push_back(8'hFF);
		tx_bytes.push_back(8'hAA);
		add_frame(stim_gyro, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		tx_bytes.push_back(stim_header);
		add_frame(stim_angle, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b0);
		add_frame(stim_angle, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h1234, 1'b0);
		add_frame(stim_angle, 16'h0001, 16'h0002, 16'hFFFF, 16'h0003, 1'b0);
		add_frame(stim_angle, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 1'b0);
		add_frame(stim_angle, 16'h0000, 16'h0000, 16'hFFFE, 16'h0000, 1'b0);
		add_frame(stim_angle, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 1'b0);
		add_frame(stim_angle, 16'h1111, 16'h2222, 16'h4000, 16'h3333, 1'b1);
		add_frame(stim_accel, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b0);
		add_frame(8'h00, 16'hABCD, 16'h1234, 16'h5678, 16'h9ABC, 1'b0);
		add_frame(8'hFF, 16'hABCD, 16'h1234, 16'h5678, 16'h9ABC, 1'b0);
		stim_last_yaw = 16'h7FFF;
		random_traffic(PHASE_BYTES);
		wait_idle();

		// Extreme header, accelerometer frames disabled through bit 0 only.
		set_config(8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE);
		write_unused_regs();
		random_traffic(PHASE_BYTES);
		wait_idle();

		// All type codes equal: accelerometer wins.
		set_config(8'hFF, 8'h10, 8'h10, 8'h10, 8'h01);
		random_traffic(PHASE_BYTES);
		wait_idle();

		// Accelerometer and gyro codes collide while accelerometer is disabled.
		set_config(8'hAA, 8'h20, 8'h20, 8'h21, 8'h00);
		random_traffic(PHASE_BYTES);
		wait_idle();

		set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		write_unused_regs();
		random_traffic(PHASE_BYTES);
		wait_idle();

		set_config(HEADER_RESET, ACCEL_CODE_RESET, GYRO_CODE_RESET, ANGLE_CODE_RESET, 8'hFF);
		random_traffic(PHASE_BYTES);
		wait_idle();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_frames.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
